[design/assert_macros.svh]
// Assertion macros used by the neuron training step top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk with rst_n low as the disable
`define NTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk with rst_n low as the disable
`define NTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/nts_pkg.sv]
// Shared types, constants and saturating helpers for the neuron training step
package nts_pkg;

    localparam int IDX_W          = 6;
    localparam int DATA_W         = 32;
    localparam int LR_W           = 17;
    localparam int OP_W           = 3;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int MAX_INPUTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam logic [LR_W-1:0] LR_RESET = 17'd655;

    // stream payload widths; the tdata widths are padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = DATA_W;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_FWD  = 3'd0,
        OP_BWD  = 3'd1,
        OP_CLR  = 3'd2,
        OP_DESC = 3'd3,
        OP_LDW  = 3'd4,
        OP_LDB  = 3'd5
    } op_t;

    // control from sequencer to arithmetic unit
    typedef struct packed {
        op_t  op;
        logic in_range;
        logic idx_zero;
    } mac_ctl_t;

    // control from sequencer to element stores
    typedef struct packed {
        logic rd_en;
        logic wt_we;
        logic gr_we;
    } mem_ctl_t;

    // clamp a 33-bit sum to 32-bit signed
    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] x);
        logic signed [DATA_W-1:0] r;
        if (x[DATA_W] != x[DATA_W-1])
            r = x[DATA_W] ? Q_MIN : Q_MAX;
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return sat33(s);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        return sat33(s);
    endfunction

    // clamp a full-width product to 32-bit signed
    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [PROD_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if ((&x[PROD_W-1:DATA_W-1]) || !(|x[PROD_W-1:DATA_W-1]))
            r = x[DATA_W-1:0];
        else
            r = x[PROD_W-1] ? Q_MIN : Q_MAX;
        return r;
    endfunction

endpackage

[design/nts_store.sv]
// Weight and gradient element memories with registered read and gradient valid bits
module nts_store
    import nts_pkg::*;
#(
    parameter int DEPTH = MAX_INPUTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mem_ctl_t                 ctl,
    input  logic [AW-1:0]            rd_addr,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [DATA_W-1:0] wt_wdata,
    input  logic signed [DATA_W-1:0] gr_wdata,
    output logic signed [DATA_W-1:0] wt_rdata,
    output logic signed [DATA_W-1:0] gr_rdata
);

    logic signed [DATA_W-1:0] wt_mem [DEPTH];
    logic signed [DATA_W-1:0] gr_mem [DEPTH];
    logic [DEPTH-1:0]         gr_vld_reg;
    logic                     gr_rvld_reg;
    logic signed [DATA_W-1:0] wt_q_reg;
    logic signed [DATA_W-1:0] gr_q_reg;

    // memory arrays: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wt_we)
            wt_mem[wr_addr] <= wt_wdata;
        if (ctl.gr_we)
            gr_mem[wr_addr] <= gr_wdata;
        if (ctl.rd_en)
        begin
            wt_q_reg <= wt_mem[rd_addr];
            gr_q_reg <= gr_mem[rd_addr];
        end
    end

    // gradient entries read as zero until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gr_vld_reg  <= '0;
            gr_rvld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.gr_we)
                gr_vld_reg[wr_addr] <= 1'b1;
            if (ctl.rd_en)
                gr_rvld_reg <= gr_vld_reg[rd_addr];
        end
    end

    assign wt_rdata = wt_q_reg;
    assign gr_rdata = gr_rvld_reg ? gr_q_reg : '0;

endmodule

[design/nts_mac.sv]
// Multiplier stage and saturating update arithmetic for one element word
module nts_mac
    import nts_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  mac_ctl_t                 ctl,
    input  logic                     mul_en,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] grad,
    input  logic signed [DATA_W-1:0] wt_rd,
    input  logic signed [DATA_W-1:0] gr_rd,
    input  logic signed [DATA_W-1:0] bias,
    input  logic signed [DATA_W-1:0] bgrad,
    input  logic signed [DATA_W-1:0] fsum,
    input  logic [LR_W-1:0]          lrate,
    output logic signed [DATA_W-1:0] wt_new,
    output logic signed [DATA_W-1:0] gr_new,
    output logic signed [DATA_W-1:0] bias_new,
    output logic signed [DATA_W-1:0] bgrad_new,
    output logic signed [DATA_W-1:0] fsum_new
);

    logic signed [DATA_W-1:0] opa;
    logic signed [DATA_W-1:0] opb;
    logic signed [DATA_W-1:0] lr_s;
    logic signed [PROD_W-1:0] prod_a_reg;
    logic signed [PROD_W-1:0] prod_b_reg;
    logic signed [DATA_W-1:0] term_a;
    logic signed [DATA_W-1:0] term_b;
    logic signed [DATA_W-1:0] fwd_base;

    assign lr_s = $signed({{(DATA_W-LR_W){1'b0}}, lrate});

    // operand select for the shared element multiplier
    always_comb
    begin
        case (ctl.op)
            OP_BWD:
            begin
                opa = grad;
                opb = value;
            end
            OP_DESC:
            begin
                opa = gr_rd;
                opb = lr_s;
            end
            default:
            begin
                opa = value;
                opb = wt_rd;
            end
        endcase
    end

    // product registers: element product and bias step product
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_a_reg <= opa * opb;
            prod_b_reg <= bgrad * lr_s;
        end
    end

    // scale back to fixed point, floor rounding, then clamp
    assign term_a = sat_wide(prod_a_reg >>> FRAC_BITS);
    assign term_b = sat_wide(prod_b_reg >>> FRAC_BITS);

    // forward sum restarts from the bias at element zero
    assign fwd_base = ctl.idx_zero ? bias : fsum;
    assign fsum_new = sat_add(fwd_base, ctl.in_range ? term_a : '0);

    // write-back values per operation
    always_comb
    begin
        wt_new    = wt_rd;
        gr_new    = gr_rd;
        bias_new  = bias;
        bgrad_new = bgrad;
        case (ctl.op)
            OP_BWD:
            begin
                gr_new    = sat_add(gr_rd, term_a);
                bgrad_new = sat_add(bgrad, grad);
            end
            OP_CLR:
            begin
                gr_new    = '0;
                bgrad_new = '0;
            end
            OP_DESC:
            begin
                wt_new   = sat_sub(wt_rd, term_a);
                bias_new = sat_sub(bias, term_b);
            end
            OP_LDW:
                wt_new = value;
            OP_LDB:
                bias_new = value;
            default:
            begin
                wt_new = wt_rd;
            end
        endcase
    end

endmodule

[design/neuron_train_step_top.sv]
// Top level of the neuron training step: sequencer, bias registers and stream ports
//
// Channel   Dir  Handshake                  Payload
// s_*       in   s_tvalid / s_tready        tdata: index, value, grad; tuser: operation;
//                                           tlast: last
// m_*       out  m_tvalid / m_tready        tdata: total
// cfg_*     in   cfg_valid / cfg_ready      cfg_data: descent step size
//
// Each word passes through accept with memory read, multiply, then write back.
// The single read-modify-write path through the element memories admits no new word until write back ends.
// A forward word with tlast stays in write back while an earlier total is not taken.
// Reset clears control, bias terms, sum and gradient valid bits at once; no sweep.
// Config writes are always ready and take effect on the next word.
`include "assert_macros.svh"

module neuron_train_step_top
    import nts_pkg::*;
#(
    parameter int MAX_INPUTS = MAX_INPUTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // index[5:0], value[37:6], grad[69:38], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,   // operation[2:0]
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // total[31:0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LR_W-1:0]      cfg_data
);

    localparam int IDX_SPAN = 1 << IDX_W;
    localparam int DEPTH    = (MAX_INPUTS < IDX_SPAN) ? MAX_INPUTS : IDX_SPAN;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RD   = 3'b010,
        ST_WB   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // item registers
    op_t                      op_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] grad_reg;
    logic                     last_reg;

    // neuron scalars and config
    logic signed [DATA_W-1:0] bias_reg;
    logic signed [DATA_W-1:0] bgrad_reg;
    logic signed [DATA_W-1:0] fsum_reg;
    logic [LR_W-1:0]          lr_reg;

    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;

    logic                     accept;
    logic [IDX_W-1:0]         in_idx;
    logic                     in_idx_ok;
    logic                     in_range;
    logic                     idx_zero;
    logic                     emit;
    logic                     stall;
    logic                     commit;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    mem_ctl_t                 mem_ctl;
    mac_ctl_t                 mac_ctl;
    logic signed [DATA_W-1:0] wt_rd;
    logic signed [DATA_W-1:0] gr_rd;
    logic signed [DATA_W-1:0] wt_new;
    logic signed [DATA_W-1:0] gr_new;
    logic signed [DATA_W-1:0] bias_new;
    logic signed [DATA_W-1:0] bgrad_new;
    logic signed [DATA_W-1:0] fsum_new;

    // input handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_idx   = s_tdata[IDX_W-1:0];

    assign in_idx_ok = (32'(in_idx) < 32'(DEPTH));
    assign in_range  = (32'(idx_reg) < 32'(DEPTH));
    assign idx_zero  = (idx_reg == '0);
    assign rd_addr   = in_idx_ok ? in_idx[AW-1:0] : '0;
    assign wr_addr   = in_range ? idx_reg[AW-1:0] : '0;

    // result gating: hold write back while the output word is still pending
    assign emit   = (op_reg == OP_FWD) && last_reg;
    assign stall  = emit && m_tvalid_reg && !m_tready;
    assign commit = (state_reg == ST_WB) && !stall;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_RD;
            ST_RD:
                state_next = ST_WB;
            ST_WB:
                if (!stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // capture the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(s_tuser);
            idx_reg   <= in_idx;
            value_reg <= $signed(s_tdata[IDX_W+DATA_W-1:IDX_W]);
            grad_reg  <= $signed(s_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W]);
            last_reg  <= s_tlast;
        end
    end

    // memory and arithmetic control
    always_comb
    begin
        mem_ctl.rd_en = accept;
        mem_ctl.wt_we = commit && in_range && ((op_reg == OP_DESC) || (op_reg == OP_LDW));
        mem_ctl.gr_we = commit && in_range && ((op_reg == OP_BWD) || (op_reg == OP_CLR));
        mac_ctl.op       = op_reg;
        mac_ctl.in_range = in_range;
        mac_ctl.idx_zero = idx_zero;
    end

    nts_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wt_wdata (wt_new),
        .gr_wdata (gr_new),
        .wt_rdata (wt_rd),
        .gr_rdata (gr_rd)
    );

    nts_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .ctl       (mac_ctl),
        .mul_en    (state_reg == ST_RD),
        .value     (value_reg),
        .grad      (grad_reg),
        .wt_rd     (wt_rd),
        .gr_rd     (gr_rd),
        .bias      (bias_reg),
        .bgrad     (bgrad_reg),
        .fsum      (fsum_reg),
        .lrate     (lr_reg),
        .wt_new    (wt_new),
        .gr_new    (gr_new),
        .bias_new  (bias_new),
        .bgrad_new (bgrad_new),
        .fsum_new  (fsum_new)
    );

    // bias terms, running sum and step size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg  <= '0;
            bgrad_reg <= '0;
            fsum_reg  <= '0;
            lr_reg    <= LR_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                lr_reg <= cfg_data;
            if (commit && (op_reg == OP_FWD))
                fsum_reg <= fsum_new;
            if (commit && idx_zero && ((op_reg == OP_BWD) || (op_reg == OP_CLR)))
                bgrad_reg <= bgrad_new;
            if (commit && (((op_reg == OP_DESC) && idx_zero) || (op_reg == OP_LDB)))
                bias_reg <= bias_new;
        end
    end

    assign cfg_ready = 1'b1;

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (commit && emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit && emit)
            m_tdata_reg <= fsum_new;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `NTS_ASSERT_NXT(a_accept_to_read, accept, state_reg == ST_RD,
        "accepted word did not move to the read stage")
    `NTS_ASSERT_NOW(a_mem_write_in_wb, mem_ctl.wt_we || mem_ctl.gr_we, state_reg == ST_WB,
        "element memory written outside write back")
    `NTS_ASSERT_NXT(a_stall_holds_wb, (state_reg == ST_WB) && stall, state_reg == ST_WB,
        "write back left while the output word was blocked")
    `NTS_ASSERT_NOW(a_out_from_fwd_last, $rose(m_tvalid_reg),
        $past(state_reg == ST_WB) && $past(emit),
        "output word raised without a forward last word")

endmodule
